### src/rdc_pkg.sv
// rdc_pkg: shared constants, control/status structs and the digit glyph lookup
// for the radix digit converter. No dependencies.
package rdc_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int MAX_DIGITS  = 31;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 5;
    localparam int CHAR_W      = 7;
    localparam int OUT_TDATA_W = ((CHAR_W + 7) / 8) * 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(30);
    localparam logic [DIGIT_W-1:0] DIGIT_TOP = DIGIT_W'(29);

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // take a new request
        logic step;      // one restoring-division bit
        logic store;     // save remainder, start next digit or finish
        logic rd;        // read one stored digit
        logic out_load;  // move read digit into the output register
    } t_rdc_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic bit_last;  // final bit of the current division
        logic conv_done; // quotient is zero or the digit store is full
        logic out_free;  // output register free by the next edge
        logic rd_last;   // digit being read is the least significant
    } t_rdc_sts;

    // digit 0..29 to '0'-'9', 'A'-'T'; codes above 29 saturate
    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] ds;
        ds = (d > DIGIT_TOP) ? DIGIT_TOP : d;
        if (ds < DIGIT_W'(10)) begin
            glyph = CHAR_W'(48) + CHAR_W'(ds);
        end else begin
            glyph = CHAR_W'(55) + CHAR_W'(ds);
        end
    endfunction

endpackage

### src/rdc_ctrl.sv
// rdc_ctrl: sequencing state machine of the radix digit converter.
// Depends on rdc_pkg for the command and status structs.
module rdc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  rdc_pkg::t_rdc_sts i_sts,
    output rdc_pkg::t_rdc_cmd o_cmd,
    output logic              o_idle
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_STORE,
        ST_RD,
        ST_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_sts.bit_last) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                n_state = i_sts.conv_done ? ST_RD : ST_DIV;
            end
            ST_RD: begin
                if (i_sts.out_free) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = i_sts.rd_last ? ST_IDLE : ST_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_idle          = (r_state == ST_IDLE);
        o_cmd.load      = (r_state == ST_IDLE) && i_accept;
        o_cmd.step      = (r_state == ST_DIV);
        o_cmd.store     = (r_state == ST_STORE);
        o_cmd.rd        = (r_state == ST_RD) && i_sts.out_free;
        o_cmd.out_load  = (r_state == ST_LOAD);
    end

endmodule

### src/rdc_datapath.sv
// rdc_datapath: bit-serial restoring divider, digit store memory and output register.
// Depends on rdc_pkg for constants, structs and the glyph lookup.
module rdc_datapath #(
    parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH,
    parameter int MAX_DIGITS  = rdc_pkg::MAX_DIGITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rdc_pkg::t_rdc_cmd              i_cmd,
    output rdc_pkg::t_rdc_sts              o_sts,
    input  logic [VALUE_WIDTH-1:0]         i_value,
    input  logic [rdc_pkg::RADIX_W-1:0]    i_radix,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [rdc_pkg::CHAR_W-1:0]     o_out_char,
    output logic                           o_out_last
);

    localparam int BIT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int DW    = rdc_pkg::DIGIT_W;

    logic [VALUE_WIDTH-1:0]      r_quot;
    logic [DW-1:0]               r_rem;
    logic [rdc_pkg::RADIX_W-1:0] r_base;
    logic [BIT_W-1:0]            r_bit;
    logic [IDX_W-1:0]            r_wr_idx;
    logic [IDX_W-1:0]            r_rd_idx;
    logic [DW-1:0]               r_rd_data;
    logic [DW-1:0]               r_store [MAX_DIGITS];
    logic                        r_out_valid;
    logic [rdc_pkg::CHAR_W-1:0]  r_out_char;
    logic                        r_out_last;

    logic [rdc_pkg::RADIX_W-1:0] n_base;
    logic [DW:0]                 n_trial;
    logic [DW:0]                 n_diff;
    logic                        n_ge;
    logic                        n_done;

    always_comb begin
        if (i_radix < rdc_pkg::RADIX_MIN) begin
            n_base = rdc_pkg::RADIX_MIN;
        end else if (i_radix > rdc_pkg::RADIX_MAX) begin
            n_base = rdc_pkg::RADIX_MAX;
        end else begin
            n_base = i_radix;
        end
        n_trial = {r_rem, r_quot[VALUE_WIDTH-1]};
        n_ge    = (n_trial >= {1'b0, r_base});
        n_diff  = n_trial - {1'b0, r_base};
        n_done  = (r_quot == '0) || (r_wr_idx == IDX_W'(MAX_DIGITS - 1));
    end

    // divider, digit counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quot   <= i_value;
            r_base   <= n_base;
            r_rem    <= '0;
            r_bit    <= '0;
            r_wr_idx <= '0;
        end else if (i_cmd.step) begin
            // remainder stays below the base, so it fits in DW bits
            r_rem  <= n_ge ? n_diff[DW-1:0] : n_trial[DW-1:0];
            r_quot <= {r_quot[VALUE_WIDTH-2:0], n_ge};
            r_bit  <= r_bit + BIT_W'(1);
        end else if (i_cmd.store) begin
            r_rem <= '0;
            r_bit <= '0;
            if (n_done) begin
                r_rd_idx <= r_wr_idx;
            end else begin
                r_wr_idx <= r_wr_idx + IDX_W'(1);
            end
        end else if (i_cmd.out_load) begin
            r_rd_idx <= r_rd_idx - IDX_W'(1);
        end
    end

    // digit store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_store[r_wr_idx] <= r_rem;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_store[r_rd_idx];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_char <= rdc_pkg::glyph(r_rd_data);
            r_out_last <= (r_rd_idx == '0);
        end
    end

    always_comb begin
        o_sts.bit_last  = (r_bit == BIT_W'(VALUE_WIDTH - 1));
        o_sts.conv_done = n_done;
        o_sts.out_free  = !r_out_valid || i_out_ready;
        o_sts.rd_last   = (r_rd_idx == '0);
        o_out_valid     = r_out_valid;
        o_out_char      = r_out_char;
        o_out_last      = r_out_last;
    end

endmodule

### src/radix_digit_converter.sv
// radix_digit_converter: top level, stream ports around controller and datapath.
// Depends on rdc_pkg, rdc_ctrl and rdc_datapath.
//
// A request on the slave stream carries a non-negative value and a radix; the
// radix is clamped to 2..30. The master stream returns one ASCII character per
// digit, most significant first ('0'-'9' then 'A'-'T'), with tlast on the
// least significant digit. Zero gives the single digit '0'. A value with more
// than MAX_DIGITS digits yields only its MAX_DIGITS low digits.
// Each digit comes from one pass of a shared bit-serial restoring divider that
// resolves one quotient bit per cycle and then stores the remainder as a
// digit. After the last division, each digit is read from the store and then
// loaded into the output register.
// tready is high only while no conversion is in progress; the next request is
// taken while the final digit still waits in the output register.
// A stalled receiver holds the output register and the digit readout waits.
// Synchronous active-low reset returns to idle and empties the output register;
// the digit store needs no clearing.
module radix_digit_converter #(
    parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH,
    parameter int MAX_DIGITS  = rdc_pkg::MAX_DIGITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [VALUE_WIDTH-1:0] value, then radix (5 bits), zero padded to bytes
    input  logic [((VALUE_WIDTH + rdc_pkg::RADIX_W + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // [6:0] digit_char, [7] zero
    output logic [rdc_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    output logic                                  o_m_axis_tlast
);

    rdc_pkg::t_rdc_cmd              cmd;
    rdc_pkg::t_rdc_sts              sts;
    logic                           idle;
    logic                           accept;
    logic [rdc_pkg::CHAR_W-1:0]     out_char;

    // no request is taken while reset is held
    assign accept = i_s_axis_tvalid && idle && i_rst_n;
    assign o_s_axis_tready = idle && i_rst_n;
    assign o_m_axis_tdata = rdc_pkg::OUT_TDATA_W'(out_char);

    rdc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_idle   (idle)
    );

    rdc_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_value     (i_s_axis_tdata[VALUE_WIDTH-1:0]),
        .i_radix     (i_s_axis_tdata[VALUE_WIDTH +: rdc_pkg::RADIX_W]),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_char  (out_char),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule

### bench/tb_top.sv
// tb_top: self-checking bench for radix_digit_converter, value/radix requests in,
// one ascii digit per result out, checked against a behavioral digit predictor.
// Depends on rdc_pkg and radix_digit_converter.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH;
    localparam int MAX_DIGITS  = rdc_pkg::MAX_DIGITS;
    localparam int RADIX_W     = rdc_pkg::RADIX_W;
    localparam int DIGIT_W     = rdc_pkg::DIGIT_W;
    localparam int CHAR_W      = rdc_pkg::CHAR_W;
    localparam int OUT_TDATA_W = rdc_pkg::OUT_TDATA_W;
    localparam logic [RADIX_W-1:0] RADIX_MIN = rdc_pkg::RADIX_MIN;
    localparam logic [RADIX_W-1:0] RADIX_MAX = rdc_pkg::RADIX_MAX;
    localparam logic [DIGIT_W-1:0] DIGIT_TOP = rdc_pkg::DIGIT_TOP;

    localparam int S_TDATA_W    = ((VALUE_WIDTH + RADIX_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_ITEMS = 128;
    localparam int SETTLE_CYCLES = 1100;
    localparam string DIGIT_GLYPHS = "0123456789ABCDEFGHIJKLMNOPQRST";
    localparam logic [VALUE_WIDTH-1:0] VALUE_TOP = '1;

    typedef struct packed {
        logic [CHAR_W-1:0] glyph_code;
        logic              is_last;
    } t_digit;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // [30:0] value, [35:31] radix, [39:36] zero
    logic [S_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // [6:0] digit_char, [7] zero
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;

    t_digit      pending_digits[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned out_hold_cycles = 0;
    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;

    radix_digit_converter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // divide down by the clamped radix, then queue digits most significant first
    function automatic void predict_digits(input logic [VALUE_WIDTH-1:0] value,
                                           input logic [RADIX_W-1:0] radix);
        logic [VALUE_WIDTH-1:0] quotient;
        logic [DIGIT_W-1:0]     remainders[MAX_DIGITS];
        int unsigned            base;
        int unsigned            count;
        int unsigned            rem;
        t_digit                 d;
        base = 32'(radix);
        if (base < RADIX_MIN) begin
            base = RADIX_MIN;
        end
        if (base > RADIX_MAX) begin
            base = RADIX_MAX;
        end
        quotient = value;
        count = 0;
        do begin
            remainders[count] = DIGIT_W'(quotient % base);
            quotient = VALUE_WIDTH'(quotient / base);
            count++;
        end while (quotient != 0 && count < MAX_DIGITS);
        for (int k = 0; k < count; k++) begin
            rem = 32'(remainders[count - 1 - k]);
            if (rem > DIGIT_TOP) begin
                rem = DIGIT_TOP;
            end
            d.glyph_code = CHAR_W'(DIGIT_GLYPHS[rem]);
            d.is_last = (k + 1 == count);
            pending_digits.push_back(d);
        end
    endfunction

    // offer one request and hold it until taken; tvalid stays high afterwards
    task automatic send_request(input logic [VALUE_WIDTH-1:0] value,
                                input logic [RADIX_W-1:0] radix);
        int unsigned gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 99) < 35) begin
            gap = pick_gap();
        end
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= S_TDATA_W'({radix, value});
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_digits(value, radix);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_digits.size() != 0);
    endtask

    always @(posedge i_clk) begin
        t_digit want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_digits.size() == 0) begin
                report_mismatch("unexpected digit", o_m_axis_tdata[CHAR_W-1:0], 0);
            end else begin
                want = pending_digits.pop_front();
                if (o_m_axis_tdata[CHAR_W-1:0] != want.glyph_code) begin
                    report_mismatch("digit_char", o_m_axis_tdata[CHAR_W-1:0],
                                    want.glyph_code);
                end
                if (o_m_axis_tlast != want.is_last) begin
                    report_mismatch("last_digit", o_m_axis_tlast, want.is_last);
                end
            end
        end
    end

    // receiver: one tready decision per stretch, long hold when a test asks
    initial begin : receiver
        int unsigned stretch;
        logic        ready_level;
        @(posedge i_clk);
        forever begin
            if (out_hold_cycles != 0) begin
                ready_level = 1'b0;
                stretch = out_hold_cycles;
                out_hold_cycles = 0;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                ready_level = 1'b0;
                stretch = pick_gap();
            end else begin
                ready_level = 1'b1;
                stretch = $urandom_range(1, 8);
            end
            i_m_axis_tready <= ready_level;
            repeat (stretch) @(posedge i_clk);
        end
    end

    task automatic test_zero_value();
        send_request('0, 5'd10);
        send_request('0, 5'd2);
        send_request('0, 5'd30);
        send_request('0, 5'd0);
        drain_results();
    endtask

    task automatic test_extreme_values();
        send_request(VALUE_TOP, 5'd2);
        send_request(VALUE_TOP, 5'd30);
        send_request(VALUE_TOP, 5'd10);
        send_request(VALUE_TOP, 5'd16);
        send_request(VALUE_WIDTH'(1) << (VALUE_WIDTH - 1), 5'd2);
        send_request(VALUE_WIDTH'(1), 5'd2);
        send_request(VALUE_WIDTH'(29), 5'd30);
        send_request(VALUE_WIDTH'(30), 5'd30);
        drain_results();
    endtask

    // radix 0 and 1 act as base 2, 31 acts as base 30
    task automatic test_radix_clamp();
        send_request(VALUE_WIDTH'(5), 5'd0);
        send_request(VALUE_WIDTH'(5), 5'd1);
        send_request(VALUE_WIDTH'(899), 5'd31);
        send_request(VALUE_WIDTH'(255), 5'd31);
        send_request(VALUE_TOP, 5'd0);
        send_request(VALUE_TOP, 5'd31);
        drain_results();
    endtask

    task automatic test_random_stream();
        logic [VALUE_WIDTH-1:0] value;
        logic [RADIX_W-1:0]     radix;
        int unsigned            pick;
        int unsigned            phase;
        int unsigned            width;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            phase = i / 32;
            tx_idle_en = (phase == 0 || phase == 2);
            rx_idle_en = (phase == 0 || phase == 3);
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                width = $urandom_range(1, VALUE_WIDTH);
                value = VALUE_WIDTH'(VALUE_WIDTH'($urandom)
                                     & ((VALUE_WIDTH'(1) << width) - 1));
            end else if (pick < 75) begin
                value = VALUE_WIDTH'($urandom);
            end else begin
                value = VALUE_WIDTH'($urandom_range(0, 40));
            end
            if ($urandom_range(0, 99) < 85) begin
                radix = RADIX_W'($urandom_range(2, 30));
            end else begin
                radix = RADIX_W'($urandom_range(0, 31));
            end
            send_request(value, radix);
        end
        drain_results();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // receiver stalls long while requests keep coming, so the block backs up
    task automatic test_output_backpressure();
        tx_idle_en = 1'b0;
        out_hold_cycles = 600;
        for (int i = 0; i < 6; i++) begin
            send_request(VALUE_WIDTH'($urandom_range(0, 255)),
                         RADIX_W'($urandom_range(2, 4)));
        end
        drain_results();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_paused_sender();
        for (int i = 0; i < 8; i++) begin
            send_request(VALUE_WIDTH'($urandom), RADIX_W'($urandom_range(0, 31)));
            drain_results();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_value();
        test_extreme_values();
        test_radix_clamp();
        test_output_backpressure();
        test_paused_sender();
        test_random_stream();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
